FILE: rtl/text_to_signed_integer_core_assert.svh
// Assertion macros shared by the text-to-integer converter modules.
`ifndef TEXT_TO_SIGNED_INTEGER_CORE_ASSERT_SVH
`define TEXT_TO_SIGNED_INTEGER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define TTSI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define TTSI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ttsi_pkg.sv
// Shared constants and types of the text-to-integer converter.
package ttsi_pkg;

	localparam int VALUE_BITS = 64;
	localparam int OFFS_W = 16;
	localparam int RADIX_W = 6;
	localparam int BYTE_W = 8;
	localparam int DIGIT_W = 6;
	localparam int MAX_STRING_LEN = 65535;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [DIGIT_W-1:0] NO_DIGIT = '1;
	localparam logic [VALUE_BITS-1:0] MAG_LIMIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// One character after classification by the front end.
	typedef struct packed {
		logic is_nul;
		logic is_space;
		logic is_plus;
		logic is_minus;
		logic is_x;
		logic is_zero;
		logic [DIGIT_W-1:0] digit;
	} char_class_t;

endpackage

FILE: rtl/ttsi_front.sv
// Input side: takes characters and classifies them for the scanner.
module ttsi_front (
	input  logic in_valid,
	output logic in_ready,
	input  logic [ttsi_pkg::BYTE_W-1:0] char_byte,
	input  logic queue_full,
	output logic push,
	output ttsi_pkg::char_class_t push_data
);

	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_NUL = 8'h00;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_TAB = 8'h09;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_CR = 8'h0d;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_PLUS = 8'h2b;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_ZERO = 8'h30;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_NINE = 8'h39;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_UP_A = 8'h41;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_UP_X = 8'h58;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_UP_Z = 8'h5a;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_LO_A = 8'h61;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_LO_X = 8'h78;
	localparam logic [ttsi_pkg::BYTE_W-1:0] CH_LO_Z = 8'h7a;

	function automatic logic [ttsi_pkg::DIGIT_W-1:0] digit_of(
		input logic [ttsi_pkg::BYTE_W-1:0] b
	);
		logic [ttsi_pkg::BYTE_W-1:0] d;
		begin
			d = ttsi_pkg::BYTE_W'(ttsi_pkg::NO_DIGIT);
			if (b >= CH_ZERO && b <= CH_NINE) begin
				d = b - CH_ZERO;
			end else if (b >= CH_LO_A && b <= CH_LO_Z) begin
				d = b - CH_LO_A + 8'd10;
			end else if (b >= CH_UP_A && b <= CH_UP_Z) begin
				d = b - CH_UP_A + 8'd10;
			end
			return d[ttsi_pkg::DIGIT_W-1:0];
		end
	endfunction

	assign in_ready = !queue_full;
	assign push = in_valid && in_ready;

	always_comb begin
		push_data.is_nul = (char_byte == CH_NUL);
		push_data.is_space = (char_byte == CH_SPACE) ||
			(char_byte >= CH_TAB && char_byte <= CH_CR);
		push_data.is_plus = (char_byte == CH_PLUS);
		push_data.is_minus = (char_byte == CH_MINUS);
		push_data.is_x = (char_byte == CH_LO_X) || (char_byte == CH_UP_X);
		push_data.is_zero = (char_byte == CH_ZERO);
		push_data.digit = digit_of(char_byte);
	end

endmodule

FILE: rtl/ttsi_queue.sv
// Short queue of classified characters between the front end and the scanner.
`include "text_to_signed_integer_core_assert.svh"

module ttsi_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ttsi_pkg::char_class_t push_data,
	output logic full,
	input  logic pop,
	output ttsi_pkg::char_class_t pop_data,
	output logic not_empty
);

	ttsi_pkg::char_class_t entry_q [ttsi_pkg::QUEUE_DEPTH];
	logic [ttsi_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [ttsi_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [ttsi_pkg::QCNT_W-1:0] count_q;

	assign full = (count_q == ttsi_pkg::QCNT_W'(ttsi_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ttsi_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ttsi_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + ttsi_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - ttsi_pkg::QCNT_W'(1);
			end
		end
	end

	`TTSI_ASSERT_IMP(a_queue_no_overfill, 1'b1, count_q <= ttsi_pkg::QCNT_W'(ttsi_pkg::QUEUE_DEPTH), "queue count beyond depth")
	`TTSI_ASSERT_IMP(a_queue_pop_nonempty, pop, count_q != '0, "pop from empty queue")
	`TTSI_ASSERT_IMP(a_queue_push_room, push, !full, "push into full queue")
	`TTSI_ASSERT_NXT(a_queue_count_tracks, push && !pop, count_q == $past(count_q) + ttsi_pkg::QCNT_W'(1), "queue count lost a push")

endmodule

FILE: rtl/ttsi_back.sv
// Scanner: runs the conversion state machine and holds the result register.
`include "text_to_signed_integer_core_assert.svh"

module ttsi_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [ttsi_pkg::RADIX_W-1:0] radix_q,
	input  logic not_empty,
	input  ttsi_pkg::char_class_t pop_data,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic [ttsi_pkg::VALUE_BITS-1:0] value,
	output logic [ttsi_pkg::OFFS_W-1:0] end_offset,
	output logic range_error
);

	localparam logic [2:0] PH_LEAD = 3'd0;
	localparam logic [2:0] PH_SIGNED = 3'd1;
	localparam logic [2:0] PH_ZERO = 3'd2;
	localparam logic [2:0] PH_ZEROX = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	localparam int PROD_W = ttsi_pkg::VALUE_BITS + ttsi_pkg::RADIX_W;
	localparam logic [ttsi_pkg::RADIX_W-1:0] BASE_OCT = ttsi_pkg::RADIX_W'(8);
	localparam logic [ttsi_pkg::RADIX_W-1:0] BASE_DEC = ttsi_pkg::RADIX_W'(10);
	localparam logic [ttsi_pkg::RADIX_W-1:0] BASE_HEX = ttsi_pkg::RADIX_W'(16);
	localparam logic [ttsi_pkg::RADIX_W-1:0] BASE_MAX = ttsi_pkg::RADIX_W'(36);
	localparam logic [ttsi_pkg::RADIX_W-1:0] BASE_ONE = ttsi_pkg::RADIX_W'(1);
	localparam logic [ttsi_pkg::RADIX_W-1:0] BASE_TWO = ttsi_pkg::RADIX_W'(2);
	localparam logic [ttsi_pkg::OFFS_W-1:0] POS_MAX = ttsi_pkg::OFFS_W'(ttsi_pkg::MAX_STRING_LEN);

	logic [2:0] phase_q;
	logic negative_q;
	logic [ttsi_pkg::VALUE_BITS-1:0] acc_q;
	logic overflowed_q;
	logic [ttsi_pkg::RADIX_W-1:0] base_q;
	logic [ttsi_pkg::OFFS_W-1:0] pos_q;
	logic [ttsi_pkg::OFFS_W-1:0] stop_q;

	logic out_valid_q;
	logic [ttsi_pkg::VALUE_BITS-1:0] value_q;
	logic [ttsi_pkg::OFFS_W-1:0] end_offset_q;
	logic range_error_q;

	logic first;
	logic [2:0] ph0;
	logic [ttsi_pkg::RADIX_W-1:0] base_cur;
	logic [ttsi_pkg::RADIX_W-1:0] base_take;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] sum;
	logic ovf_hit;
	logic dig_ok;
	logic [ttsi_pkg::VALUE_BITS-1:0] acc_tk;
	logic ovf_tk;
	logic [ttsi_pkg::OFFS_W-1:0] pos_prev;
	logic emit;
	logic rerr;
	logic [ttsi_pkg::VALUE_BITS-1:0] res_value;

	logic [2:0] phase_n;
	logic negative_n;
	logic [ttsi_pkg::VALUE_BITS-1:0] acc_n;
	logic overflowed_n;
	logic [ttsi_pkg::RADIX_W-1:0] base_n;
	logic [ttsi_pkg::OFFS_W-1:0] pos_n;
	logic [ttsi_pkg::OFFS_W-1:0] stop_n;

	// A terminator may only leave the queue when the result register has room.
	assign pop = not_empty && (!pop_data.is_nul || !out_valid_q || out_ready);
	assign emit = pop && pop_data.is_nul;

	// The radix is sampled at the first character of each string.
	assign first = (pos_q == '0) && (phase_q == PH_LEAD);
	assign base_cur = first ? radix_q : base_q;
	assign ph0 = (first && (radix_q == BASE_ONE || radix_q > BASE_MAX)) ? PH_DONE : phase_q;

	// Auto-detect resolves to octal after a leading zero and decimal otherwise.
	assign base_take = (base_cur != '0) ? base_cur : ((ph0 == PH_ZERO) ? BASE_OCT : BASE_DEC);
	assign dig_ok = (base_take >= BASE_TWO) && (ttsi_pkg::RADIX_W'(pop_data.digit) < base_take);
	assign prod = PROD_W'(acc_q) * PROD_W'(base_take);
	assign sum = prod + PROD_W'(pop_data.digit);
	assign ovf_hit = (sum > PROD_W'(ttsi_pkg::MAG_LIMIT));
	assign acc_tk = (overflowed_q || ovf_hit) ? acc_q : sum[ttsi_pkg::VALUE_BITS-1:0];
	assign ovf_tk = overflowed_q || ovf_hit;
	assign pos_prev = (pos_q == '0) ? '0 : pos_q - ttsi_pkg::OFFS_W'(1);

	always_comb begin
		phase_n = ph0;
		negative_n = negative_q;
		acc_n = acc_q;
		overflowed_n = overflowed_q;
		base_n = base_cur;
		stop_n = stop_q;
		pos_n = (pos_q != POS_MAX) ? pos_q + ttsi_pkg::OFFS_W'(1) : pos_q;
		if (first && ph0 == PH_DONE) begin
			acc_n = '0;
			negative_n = 1'b0;
			overflowed_n = 1'b0;
			stop_n = '0;
		end
		if (pop_data.is_nul) begin
			pos_n = pos_q;
			unique case (ph0) inside
				PH_ZERO: begin
					acc_n = '0;
					stop_n = pos_q;
				end
				PH_ZEROX: begin
					acc_n = '0;
					stop_n = pos_prev;
				end
				PH_DIGITS: begin
					stop_n = pos_q;
				end
				PH_LEAD, PH_SIGNED: begin
					acc_n = '0;
					negative_n = 1'b0;
					overflowed_n = 1'b0;
					stop_n = '0;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (ph0) inside
				PH_LEAD, PH_SIGNED: begin
					if (ph0 == PH_LEAD && pop_data.is_space) begin
					end else if (ph0 == PH_LEAD && (pop_data.is_plus || pop_data.is_minus)) begin
						negative_n = pop_data.is_minus;
						phase_n = PH_SIGNED;
					end else if ((base_cur == '0 || base_cur == BASE_HEX) && pop_data.is_zero) begin
						phase_n = PH_ZERO;
					end else begin
						base_n = base_take;
						if (dig_ok) begin
							acc_n = acc_tk;
							overflowed_n = ovf_tk;
							phase_n = PH_DIGITS;
						end else begin
							acc_n = '0;
							negative_n = 1'b0;
							overflowed_n = 1'b0;
							stop_n = '0;
							phase_n = PH_DONE;
						end
					end
				end
				PH_ZERO: begin
					if (pop_data.is_x) begin
						phase_n = PH_ZEROX;
					end else begin
						base_n = base_take;
						phase_n = PH_DIGITS;
						if (dig_ok) begin
							acc_n = acc_tk;
							overflowed_n = ovf_tk;
						end else begin
							stop_n = pos_q;
							phase_n = PH_DONE;
						end
					end
				end
				PH_ZEROX: begin
					// Without a hex digit after the x, the zero alone was converted.
					if (pop_data.digit < ttsi_pkg::DIGIT_W'(BASE_HEX)) begin
						base_n = BASE_HEX;
						acc_n = ttsi_pkg::VALUE_BITS'(pop_data.digit);
						phase_n = PH_DIGITS;
					end else begin
						acc_n = '0;
						stop_n = pos_prev;
						phase_n = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (dig_ok) begin
						acc_n = acc_tk;
						overflowed_n = ovf_tk;
					end else begin
						stop_n = pos_q;
						phase_n = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// The magnitude never exceeds the limit, so only the exact limit is too big
	// for a positive result.
	assign rerr = overflowed_n || (!negative_n && acc_n[ttsi_pkg::VALUE_BITS-1]);
	always_comb begin
		if (rerr) begin
			res_value = negative_n ? ttsi_pkg::MAG_LIMIT
				: ttsi_pkg::MAG_LIMIT - ttsi_pkg::VALUE_BITS'(1);
		end else begin
			res_value = negative_n ? ('0 - acc_n) : acc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			negative_q <= 1'b0;
			acc_q <= '0;
			overflowed_q <= 1'b0;
			base_q <= '0;
			pos_q <= '0;
			stop_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				phase_q <= PH_LEAD;
				negative_q <= 1'b0;
				acc_q <= '0;
				overflowed_q <= 1'b0;
				base_q <= '0;
				pos_q <= '0;
				stop_q <= '0;
			end else if (pop) begin
				phase_q <= phase_n;
				negative_q <= negative_n;
				acc_q <= acc_n;
				overflowed_q <= overflowed_n;
				base_q <= base_n;
				pos_q <= pos_n;
				stop_q <= stop_n;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q <= res_value;
			end_offset_q <= stop_n;
			range_error_q <= rerr;
		end
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign end_offset = end_offset_q;
	assign range_error = range_error_q;

	`TTSI_ASSERT_IMP(a_back_acc_bound, 1'b1, acc_q <= ttsi_pkg::MAG_LIMIT, "accumulator above magnitude limit")
	`TTSI_ASSERT_NXT(a_back_emit_valid, emit, out_valid_q, "terminator did not load a result")
	`TTSI_ASSERT_NXT(a_back_emit_clear, emit, phase_q == PH_LEAD && pos_q == '0 && acc_q == '0, "state not cleared after terminator")
	`TTSI_ASSERT_IMP(a_back_no_overwrite, emit, !out_valid_q || out_ready, "result overwritten before transfer")

endmodule

FILE: rtl/text_to_signed_integer_core.sv
// Top level of the streaming text-to-signed-integer converter.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  in       | in_valid / in_ready  | char_byte
//  out      | out_valid / out_ready| value, end_offset, range_error
//  config   | radix_we             | radix_wdata
//
// One character per cycle unless the queue is full; the scanner's single
// multiply-add by the base sets this rate. A terminator loads the result
// register when popped. Reset leaves the radix at 10 and all queues empty.
// A stalled result holds only terminators; other characters keep flowing,
// and a four-entry queue absorbs the input while the scanner waits.
module text_to_signed_integer_core (
	input  logic clk,
	input  logic arst_n,
	input  logic radix_we,
	input  logic [ttsi_pkg::RADIX_W-1:0] radix_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic [ttsi_pkg::BYTE_W-1:0] char_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic [ttsi_pkg::VALUE_BITS-1:0] value,
	output logic [ttsi_pkg::OFFS_W-1:0] end_offset,
	output logic range_error
);

	logic [ttsi_pkg::RADIX_W-1:0] radix_q;
	logic queue_full;
	logic push;
	ttsi_pkg::char_class_t push_data;
	logic pop;
	ttsi_pkg::char_class_t pop_data;
	logic not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= ttsi_pkg::RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	ttsi_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_byte  (char_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	ttsi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	ttsi_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_q     (radix_q),
		.not_empty   (not_empty),
		.pop_data    (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.end_offset  (end_offset),
		.range_error (range_error)
	);

endmodule

FILE: bench/text_to_signed_integer_core_test.sv
// Self-checking testbench for the streaming text-to-signed-integer converter.
`timescale 1ns / 100ps

module text_to_signed_integer_core_test;

	typedef enum logic [2:0] {
		SCAN_LEAD,
		SCAN_SIGNED,
		SCAN_ZERO,
		SCAN_ZEROX,
		SCAN_DIGITS,
		SCAN_DONE
	} scan_phase_t;

	typedef struct {
		logic [ttsi_pkg::VALUE_BITS-1:0] value;
		logic [ttsi_pkg::OFFS_W-1:0] end_offset;
		logic range_error;
	} conversion_t;

	typedef logic [ttsi_pkg::BYTE_W-1:0] text_t[$];

	localparam logic [ttsi_pkg::BYTE_W-1:0] NUL = 8'd0;
	localparam logic [ttsi_pkg::VALUE_BITS-1:0] VALUE_ONE = ttsi_pkg::VALUE_BITS'(1);

	logic clk = 1'b0;
	logic arst_n;
	logic radix_we;
	logic [ttsi_pkg::RADIX_W-1:0] radix_wdata;
	logic in_valid;
	logic in_ready;
	logic [ttsi_pkg::BYTE_W-1:0] char_byte;
	logic out_valid;
	logic out_ready;
	logic [ttsi_pkg::VALUE_BITS-1:0] value;
	logic [ttsi_pkg::OFFS_W-1:0] end_offset;
	logic range_error;

	// Converter state as the testbench tracks it.
	logic [ttsi_pkg::RADIX_W-1:0] radix_setting = ttsi_pkg::RADIX_RESET;
	scan_phase_t scan_phase = SCAN_LEAD;
	logic scan_negative = 1'b0;
	logic [ttsi_pkg::VALUE_BITS-1:0] scan_acc = '0;
	logic scan_overflow = 1'b0;
	logic [ttsi_pkg::RADIX_W-1:0] scan_base = '0;
	logic [ttsi_pkg::OFFS_W-1:0] scan_pos = '0;
	logic [ttsi_pkg::OFFS_W-1:0] scan_stop = '0;

	conversion_t pending_results[$];
	int failures = 0;
	int conversions_checked = 0;
	int saturated_results = 0;
	int radix_writes = 0;
	int chars_sent = 0;
	bit steady = 1'b0;

	text_to_signed_integer_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.radix_we(radix_we),
		.radix_wdata(radix_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_byte(char_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.end_offset(end_offset),
		.range_error(range_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] digit_of(logic [7:0] b);
		if (b >= "0" && b <= "9") return b - "0";
		if (b >= "a" && b <= "z") return b - "a" + 8'd10;
		if (b >= "A" && b <= "Z") return b - "A" + 8'd10;
		return 8'd255;
	endfunction

	function automatic bit is_blank(logic [7:0] b);
		return b == " " || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic void clear_scan();
		scan_phase = SCAN_LEAD;
		scan_negative = 1'b0;
		scan_acc = '0;
		scan_overflow = 1'b0;
		scan_base = '0;
		scan_pos = '0;
		scan_stop = '0;
	endfunction

	function automatic void give_up();
		scan_acc = '0;
		scan_negative = 1'b0;
		scan_overflow = 1'b0;
		scan_stop = '0;
		scan_phase = SCAN_DONE;
	endfunction

	function automatic void halt_at(logic [ttsi_pkg::OFFS_W-1:0] where);
		scan_stop = where;
		scan_phase = SCAN_DONE;
	endfunction

	// Once the magnitude would pass 2^63 it is frozen and only the flag moves.
	function automatic bit accumulate(logic [7:0] b);
		logic [7:0] d;
		logic [ttsi_pkg::VALUE_BITS-1:0] wide_base;
		d = digit_of(b);
		if (scan_base < 2 || d >= scan_base) return 1'b0;
		wide_base = ttsi_pkg::VALUE_BITS'(scan_base);
		if (!scan_overflow) begin
			if (scan_acc > (ttsi_pkg::MAG_LIMIT - ttsi_pkg::VALUE_BITS'(d)) / wide_base)
				scan_overflow = 1'b1;
			else
				scan_acc = scan_acc * wide_base + ttsi_pkg::VALUE_BITS'(d);
		end
		return 1'b1;
	endfunction

	function automatic void begin_number(logic [7:0] b);
		if ((scan_base == 0 || scan_base == 16) && b == "0") begin
			scan_phase = SCAN_ZERO;
			return;
		end
		if (scan_base == 0) scan_base = 6'd10;
		if (accumulate(b))
			scan_phase = SCAN_DIGITS;
		else
			give_up();
	endfunction

	function automatic void convert_char(logic [7:0] b);
		logic [ttsi_pkg::OFFS_W-1:0] prev;
		logic [7:0] d;
		logic rerr;
		conversion_t res;
		prev = (scan_pos != 0) ? scan_pos - ttsi_pkg::OFFS_W'(1) : '0;
		// The radix is latched by the first byte of every string.
		if (scan_pos == 0 && scan_phase == SCAN_LEAD) begin
			scan_base = radix_setting;
			if (radix_setting == 1 || radix_setting > 36) give_up();
		end
		if (b == NUL) begin
			case (scan_phase)
				SCAN_ZERO: begin
					scan_acc = '0;
					halt_at(scan_pos);
				end
				SCAN_ZEROX: begin
					scan_acc = '0;
					halt_at(prev);
				end
				SCAN_DIGITS: halt_at(scan_pos);
				SCAN_DONE: ;
				default: give_up();
			endcase
			rerr = scan_overflow ||
				(!scan_negative && scan_acc > ttsi_pkg::MAG_LIMIT - VALUE_ONE);
			if (rerr)
				res.value = scan_negative ? -ttsi_pkg::MAG_LIMIT
					: ttsi_pkg::MAG_LIMIT - VALUE_ONE;
			else
				res.value = scan_negative ? -scan_acc : scan_acc;
			res.end_offset = scan_stop;
			res.range_error = rerr;
			pending_results.push_back(res);
			clear_scan();
			return;
		end
		case (scan_phase)
			SCAN_LEAD: begin
				if (!is_blank(b)) begin
					if (b == "+" || b == "-") begin
						scan_negative = (b == "-");
						scan_phase = SCAN_SIGNED;
					end else begin
						begin_number(b);
					end
				end
			end
			SCAN_SIGNED: begin_number(b);
			SCAN_ZERO: begin
				if (b == "x" || b == "X") begin
					scan_phase = SCAN_ZEROX;
				end else begin
					if (scan_base == 0) scan_base = 6'd8;
					scan_phase = SCAN_DIGITS;
					if (!accumulate(b)) halt_at(scan_pos);
				end
			end
			SCAN_ZEROX: begin
				// A lone "0x" converts only the zero; the x is where it stopped.
				d = digit_of(b);
				if (d < 16) begin
					scan_base = 6'd16;
					scan_acc = ttsi_pkg::VALUE_BITS'(d);
					scan_phase = SCAN_DIGITS;
				end else begin
					scan_acc = '0;
					halt_at(prev);
				end
			end
			SCAN_DIGITS: if (!accumulate(b)) halt_at(scan_pos);
			default: ;
		endcase
		if (scan_pos < ttsi_pkg::MAX_STRING_LEN) scan_pos++;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin : check_result
		conversion_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no terminated string outstanding");
				failures++;
			end else begin
				want = pending_results.pop_front();
				conversions_checked++;
				if (want.range_error) saturated_results++;
				if (value !== want.value) begin
					$error("value: expected %0d, got %0d", $signed(want.value), $signed(value));
					failures++;
				end
				if (end_offset !== want.end_offset) begin
					$error("end_offset: expected %0d, got %0d", want.end_offset, end_offset);
					failures++;
				end
				if (range_error !== want.range_error) begin
					$error("range_error: expected %0d, got %0d", want.range_error,
						range_error);
					failures++;
				end
			end
		end
	end

	initial begin
		int hold;
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(1, 20);
			out_ready <= 1'b1;
			repeat (hold) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	task automatic send_char(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		convert_char(b);
		chars_sent++;
	endtask

	task automatic send_text(input text_t s);
		foreach (s[i]) send_char(s[i]);
		send_char(NUL);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
		send_char(NUL);
	endtask

	// Wait for every conversion to drain, then give the pipeline time to settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_radix(input logic [ttsi_pkg::RADIX_W-1:0] r);
		drain();
		radix_we <= 1'b1;
		radix_wdata <= r;
		@(posedge clk);
		radix_we <= 1'b0;
		radix_setting = r;
		radix_writes++;
	endtask

	function automatic logic [7:0] digit_char(int d);
		if (d < 10) return 8'(d) + "0";
		return 8'(d - 10) + ($urandom_range(0, 1) ? "a" : "A");
	endfunction

	function automatic logic [7:0] blank_char();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? " " : 8'(9 + r);
	endfunction

	// Whitespace, sign, prefix and digits in the current radix, with an
	// occasional out-of-range digit or trailing junk.
	function automatic text_t make_numeral();
		text_t s;
		int digits_base;
		int n;
		int d;
		repeat ($urandom_range(0, 3)) s.push_back(blank_char());
		case ($urandom_range(0, 3))
			0: s.push_back("+");
			1: s.push_back("-");
			default: ;
		endcase
		digits_base = (radix_setting == 1 || radix_setting > 36) ? 10 : radix_setting;
		if ((radix_setting == 0 || radix_setting == 16) && $urandom_range(0, 2) == 0) begin
			s.push_back("0");
			s.push_back($urandom_range(0, 1) ? "x" : "X");
			digits_base = 16;
		end else if (radix_setting == 0) begin
			if ($urandom_range(0, 1)) s.push_back("0");
			digits_base = (s.size() != 0 && s[s.size()-1] == "0") ? 8 : 10;
		end
		n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(15, 30);
		repeat (n) begin
			d = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 35)
				: $urandom_range(0, digits_base - 1);
			s.push_back(digit_char(d));
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(1, 255)));
		return s;
	endfunction

	function automatic text_t make_broken();
		text_t s;
		case ($urandom_range(0, 3))
			0: begin
				s.push_back($urandom_range(0, 1) ? "+" : "-");
				s.push_back($urandom_range(0, 1) ? blank_char() : 8'($urandom_range(33, 47)));
				s.push_back(digit_char($urandom_range(0, 9)));
			end
			1: begin
				s.push_back("0");
				s.push_back($urandom_range(0, 1) ? "x" : "X");
				s.push_back($urandom_range(0, 1) ? 8'($urandom_range("g", "z"))
					: 8'($urandom_range(128, 255)));
			end
			2: repeat ($urandom_range(1, 4)) s.push_back(blank_char());
			default: s.push_back($urandom_range(0, 1) ? "+" : "-");
		endcase
		return s;
	endfunction

	function automatic text_t make_noise();
		text_t s;
		repeat ($urandom_range(0, 6)) s.push_back(8'($urandom_range(1, 255)));
		return s;
	endfunction

	function automatic logic [ttsi_pkg::RADIX_W-1:0] pick_radix();
		case ($urandom_range(0, 9))
			0: return 6'd0;
			1: return 6'd16;
			2: return 6'd10;
			3: return 6'd8;
			4: return 6'd2;
			5: return 6'd36;
			6: return 6'd1;
			7: return ttsi_pkg::RADIX_W'($urandom_range(37, 63));
			default: return ttsi_pkg::RADIX_W'($urandom_range(2, 35));
		endcase
	endfunction

	task automatic test_blanks_and_signs();
		// Runs at the reset radix of ten.
		send_char(8'd9);
		send_char(8'd10);
		send_char(8'd11);
		send_char(8'd12);
		send_char(8'd13);
		send_string(" -42x");
		send_string("+7");
		send_string("+-3");
		send_string("");
		send_string("- 3");
		send_char(8'hFF);
		send_string("1");
		send_char(8'h80);
		send_string("");
	endtask

	task automatic test_prefixes();
		set_radix(6'd0);
		send_string("0x1F");
		send_string("0xg");
		send_string("017");
		send_string("-0X");
		send_string("9");
		set_radix(6'd16);
		send_string("0Xff");
		send_string("0x");
	endtask

	task automatic test_extremes();
		set_radix(6'd10);
		send_string("-9223372036854775808");
		send_string("9223372036854775808");
		set_radix(6'd36);
		send_string("zZ");
		set_radix(6'd2);
		send_string("-102");
	endtask

	task automatic test_invalid_radix();
		set_radix(6'd1);
		send_string("12");
		set_radix(6'd37);
		send_string("5");
		set_radix(6'd63);
		send_string("z");
	endtask

	task automatic test_random_strings();
		int start;
		int r;
		start = chars_sent;
		while (chars_sent - start < 850) begin
			set_radix(pick_radix());
			steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(10, 30)) begin
				r = $urandom_range(0, 99);
				if (r < 75) send_text(make_numeral());
				else if (r < 90) send_text(make_broken());
				else send_text(make_noise());
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		radix_we = 1'b0;
		radix_wdata = '0;
		in_valid = 1'b0;
		char_byte = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_blanks_and_signs();
		test_prefixes();
		test_extremes();
		test_invalid_radix();
		test_random_strings();

		drain();
		repeat (16) @(posedge clk);
		$display("Checked %0d conversions over %0d radix writes, %0d of them saturated.",
			conversions_checked, radix_writes, saturated_results);
		$display("Sent %0d characters across fixed, automatic and invalid bases.",
			chars_sent);
		if (failures == 0) begin
			$display("text_to_signed_integer_core: match");
		end else begin
			$display("text_to_signed_integer_core: mismatch");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Run did not complete in time.");
		$display("text_to_signed_integer_core: mismatch");
		$finish;
	end

endmodule
